[rtl/fgr5x7_pkg.sv]
// Shared types, constants and font tables of the 5x7 glyph renderer.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package fgr5x7_pkg;

   // Command codes of an input beat
   localparam logic CMD_PUT_CHAR   = 1'b0;
   localparam logic CMD_SET_CURSOR = 1'b1;

   // Default geometry of the frame buffer
   localparam int DEF_ROW_BYTES    = 84;
   localparam int DEF_BUFFER_BYTES = 504;

   // Character code mapping
   localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
   localparam logic [7:0] LAST_MAPPED     = 8'd151;
   localparam logic [6:0] FALLBACK_GLYPH  = 7'd116;  // code 148

   // Cursor and address arithmetic (11 bits covers every sum)
   localparam logic [9:0]  CURSOR_MAX     = 10'd1023;
   localparam logic [10:0] CELL_WIDTH     = 11'd6;
   localparam logic [10:0] ADVANCE_NORMAL = 11'd6;
   localparam logic [10:0] ADVANCE_DOUBLE = 11'd12;
   localparam logic [10:0] GAP_DOUBLE     = 11'd11;

   // Beat sequencer limits
   localparam logic [4:0] STEP_LAST_NORMAL = 5'd5;
   localparam logic [4:0] STEP_LAST_DOUBLE = 5'd20;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic       double_size;
      logic [3:0] text_column;
      logic [2:0] text_row;
   } req_payload_type;

   typedef struct packed {
      logic [9:0] write_address;
      logic [7:0] write_data;
      logic       address_in_range;
      logic       last_write;
   } rsp_payload_type;

   // Latin-1 code to glyph index (glyph code minus 32)
   function automatic logic [6:0] map_code(input logic [7:0] ch);
      logic [7:0] rel;
      rel = ch - FIRST_PRINTABLE;
      if (ch < FIRST_PRINTABLE) begin
         map_code = FALLBACK_GLYPH;
      end else if (ch > LAST_MAPPED) begin
         case (ch)
            8'hc0:   map_code = 7'd101;
            8'hc2:   map_code = 7'd99;
            8'hc7:   map_code = 7'd96;
            8'hc9:   map_code = 7'd112;
            8'hca:   map_code = 7'd104;
            8'hce:   map_code = 7'd108;
            8'he0:   map_code = 7'd101;
            8'he2:   map_code = 7'd99;
            8'he7:   map_code = 7'd103;
            8'he8:   map_code = 7'd106;
            8'he9:   map_code = 7'd98;
            8'hea:   map_code = 7'd104;
            8'heb:   map_code = 7'd105;
            8'hee:   map_code = 7'd108;
            8'hef:   map_code = 7'd107;
            8'hf4:   map_code = 7'd115;
            8'hf9:   map_code = 7'd119;
            8'hfb:   map_code = 7'd118;
            default: map_code = FALLBACK_GLYPH;
         endcase
      end else begin
         map_code = rel[6:0];
      end
   endfunction

   // Font ROM: five column bytes, column 0 in the top byte, bit 0 top pixel
   function automatic logic [39:0] glyph_rom(input logic [6:0] g);
      case (g)
         7'd0:    glyph_rom = 40'h00_00_00_00_00;
         7'd1:    glyph_rom = 40'h00_00_2f_00_00;
         7'd2:    glyph_rom = 40'h00_07_00_07_00;
         7'd3:    glyph_rom = 40'h14_7f_14_7f_14;
         7'd4:    glyph_rom = 40'h24_2a_7f_2a_12;
         7'd5:    glyph_rom = 40'hc4_c8_10_26_46;
         7'd6:    glyph_rom = 40'h36_49_55_22_50;
         7'd7:    glyph_rom = 40'h00_05_03_00_00;
         7'd8:    glyph_rom = 40'h00_1c_22_41_00;
         7'd9:    glyph_rom = 40'h00_41_22_1c_00;
         7'd10:   glyph_rom = 40'h14_08_3e_08_14;
         7'd11:   glyph_rom = 40'h08_08_3e_08_08;
         7'd12:   glyph_rom = 40'h00_00_50_30_00;
         7'd13:   glyph_rom = 40'h10_10_10_10_10;
         7'd14:   glyph_rom = 40'h00_60_60_00_00;
         7'd15:   glyph_rom = 40'h20_10_08_04_02;
         7'd16:   glyph_rom = 40'h3e_51_49_45_3e;
         7'd17:   glyph_rom = 40'h00_42_7f_40_00;
         7'd18:   glyph_rom = 40'h42_61_51_49_46;
         7'd19:   glyph_rom = 40'h21_41_45_4b_31;
         7'd20:   glyph_rom = 40'h18_14_12_7f_10;
         7'd21:   glyph_rom = 40'h27_45_45_45_39;
         7'd22:   glyph_rom = 40'h3c_4a_49_49_30;
         7'd23:   glyph_rom = 40'h01_71_09_05_03;
         7'd24:   glyph_rom = 40'h36_49_49_49_36;
         7'd25:   glyph_rom = 40'h06_49_49_29_1e;
         7'd26:   glyph_rom = 40'h00_36_36_00_00;
         7'd27:   glyph_rom = 40'h00_56_36_00_00;
         7'd28:   glyph_rom = 40'h08_14_22_41_00;
         7'd29:   glyph_rom = 40'h14_14_14_14_14;
         7'd30:   glyph_rom = 40'h00_41_22_14_08;
         7'd31:   glyph_rom = 40'h02_01_51_09_06;
         7'd32:   glyph_rom = 40'h32_49_59_51_3e;
         7'd33:   glyph_rom = 40'h7e_11_11_11_7e;
         7'd34:   glyph_rom = 40'h7f_49_49_49_36;
         7'd35:   glyph_rom = 40'h3e_41_41_41_22;
         7'd36:   glyph_rom = 40'h7f_41_41_22_1c;
         7'd37:   glyph_rom = 40'h7f_49_49_49_41;
         7'd38:   glyph_rom = 40'h7f_09_09_09_01;
         7'd39:   glyph_rom = 40'h3e_41_49_49_7a;
         7'd40:   glyph_rom = 40'h7f_08_08_08_7f;
         7'd41:   glyph_rom = 40'h00_41_7f_41_00;
         7'd42:   glyph_rom = 40'h20_40_41_3f_01;
         7'd43:   glyph_rom = 40'h7f_08_14_22_41;
         7'd44:   glyph_rom = 40'h7f_40_40_40_40;
         7'd45:   glyph_rom = 40'h7f_02_0c_02_7f;
         7'd46:   glyph_rom = 40'h7f_04_08_10_7f;
         7'd47:   glyph_rom = 40'h3e_41_41_41_3e;
         7'd48:   glyph_rom = 40'h7f_09_09_09_06;
         7'd49:   glyph_rom = 40'h3e_41_51_21_5e;
         7'd50:   glyph_rom = 40'h7f_09_19_29_46;
         7'd51:   glyph_rom = 40'h46_49_49_49_31;
         7'd52:   glyph_rom = 40'h01_01_7f_01_01;
         7'd53:   glyph_rom = 40'h3f_40_40_40_3f;
         7'd54:   glyph_rom = 40'h1f_20_40_20_1f;
         7'd55:   glyph_rom = 40'h3f_40_38_40_3f;
         7'd56:   glyph_rom = 40'h63_14_08_14_63;
         7'd57:   glyph_rom = 40'h07_08_70_08_07;
         7'd58:   glyph_rom = 40'h61_51_49_45_43;
         7'd59:   glyph_rom = 40'h00_7f_41_41_00;
         7'd60:   glyph_rom = 40'h02_04_08_10_20;
         7'd61:   glyph_rom = 40'h00_41_41_7f_00;
         7'd62:   glyph_rom = 40'h04_02_01_02_04;
         7'd63:   glyph_rom = 40'h40_40_40_40_40;
         7'd64:   glyph_rom = 40'h00_01_02_04_00;
         7'd65:   glyph_rom = 40'h20_54_54_54_78;
         7'd66:   glyph_rom = 40'h7f_48_44_44_38;
         7'd67:   glyph_rom = 40'h38_44_44_44_20;
         7'd68:   glyph_rom = 40'h38_44_44_48_7f;
         7'd69:   glyph_rom = 40'h38_54_54_54_18;
         7'd70:   glyph_rom = 40'h08_7e_09_01_02;
         7'd71:   glyph_rom = 40'h0c_52_52_52_3e;
         7'd72:   glyph_rom = 40'h7f_08_04_04_78;
         7'd73:   glyph_rom = 40'h00_44_7d_40_00;
         7'd74:   glyph_rom = 40'h20_40_44_3d_00;
         7'd75:   glyph_rom = 40'h7f_10_28_44_00;
         7'd76:   glyph_rom = 40'h00_41_7f_40_00;
         7'd77:   glyph_rom = 40'h7c_04_18_04_78;
         7'd78:   glyph_rom = 40'h7c_08_04_04_78;
         7'd79:   glyph_rom = 40'h38_44_44_44_38;
         7'd80:   glyph_rom = 40'h7c_14_14_14_08;
         7'd81:   glyph_rom = 40'h08_14_14_18_7c;
         7'd82:   glyph_rom = 40'h7c_08_04_04_08;
         7'd83:   glyph_rom = 40'h48_54_54_54_20;
         7'd84:   glyph_rom = 40'h04_3f_44_40_20;
         7'd85:   glyph_rom = 40'h3c_40_40_20_7c;
         7'd86:   glyph_rom = 40'h1c_20_40_20_1c;
         7'd87:   glyph_rom = 40'h3c_40_30_40_3c;
         7'd88:   glyph_rom = 40'h44_28_10_28_44;
         7'd89:   glyph_rom = 40'h0c_50_50_50_3c;
         7'd90:   glyph_rom = 40'h44_64_54_4c_44;
         7'd91:   glyph_rom = 40'h00_08_36_41_00;
         7'd92:   glyph_rom = 40'h00_00_7f_00_00;
         7'd93:   glyph_rom = 40'h00_41_36_08_00;
         7'd94:   glyph_rom = 40'h04_02_04_08_04;
         7'd95:   glyph_rom = 40'h00_00_36_00_00;
         7'd96:   glyph_rom = 40'h0e_51_31_11_08;
         7'd97:   glyph_rom = 40'h3c_41_40_21_7c;
         7'd98:   glyph_rom = 40'h38_54_56_55_18;
         7'd99:   glyph_rom = 40'h20_56_55_56_78;
         7'd100:  glyph_rom = 40'h20_55_54_55_78;
         7'd101:  glyph_rom = 40'h20_55_56_54_78;
         7'd102:  glyph_rom = 40'h08_08_2a_1c_08;
         7'd103:  glyph_rom = 40'h0e_51_31_11_08;
         7'd104:  glyph_rom = 40'h38_56_55_56_18;
         7'd105:  glyph_rom = 40'h38_55_54_55_18;
         7'd106:  glyph_rom = 40'h38_55_56_54_18;
         7'd107:  glyph_rom = 40'h00_45_7c_41_00;
         7'd108:  glyph_rom = 40'h00_46_7d_42_00;
         7'd109:  glyph_rom = 40'h7f_7f_7f_7f_7f;
         7'd110:  glyph_rom = 40'h7f_7f_7f_7f_7f;
         7'd111:  glyph_rom = 40'h7f_7f_7f_7f_7f;
         7'd112:  glyph_rom = 40'h7c_54_56_55_44;
         7'd113:  glyph_rom = 40'h7f_7f_7f_7f_7f;
         7'd114:  glyph_rom = 40'h7f_7f_7f_7f_7f;
         7'd115:  glyph_rom = 40'h38_46_45_46_38;
         7'd116:  glyph_rom = 40'h7f_7f_7f_7f_7f;
         7'd117:  glyph_rom = 40'h38_45_46_44_38;
         7'd118:  glyph_rom = 40'h3c_42_41_22_7c;
         7'd119:  glyph_rom = 40'h3c_41_42_20_7c;
         default: glyph_rom = 40'h00_00_00_00_00;
      endcase
   endfunction

endpackage

`default_nettype wire

[rtl/fgr5x7_if.sv]
// Valid/ready channel interfaces of the 5x7 glyph renderer.
// Depends on fgr5x7_pkg for the payload structs.
`default_nettype none

interface fgr5x7_req_if import fgr5x7_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fgr5x7_rsp_if import fgr5x7_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/font_glyph_renderer_5x7.sv]
// Top level of the 5x7 glyph renderer: cursor, font ROM read, beat sequencer.
// Depends on fgr5x7_pkg and the channel interfaces in fgr5x7_if.sv.
//
//   channel   dir   payload                                          beat
//   req_chan  in    cmd, char_code, double_size, text_column, row    one command
//   rsp_chan  out   write_address, write_data, in_range, last_write  one byte write
//
// Set cursor gives no beats. A normal character gives 6 beats, a doubled
// one 21 beats: the beat sequencer issues one buffer write per cycle while
// rsp_chan is not stalled. The next command is taken in the cycle of the
// last beat. The font ROM is read once, as the command is taken. Reset
// clears the cursor and the sequencer; a stalled rsp_chan holds the output
// register and the sequencer, and req_chan waits with it while a character is drawn.
`default_nettype none

module font_glyph_renderer_5x7 import fgr5x7_pkg::*; #(
   parameter int ROW_BYTES    = DEF_ROW_BYTES,
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
   input  wire logic     clock,
   input  wire logic     reset,
   fgr5x7_req_if.sink    req_chan,
   fgr5x7_rsp_if.source  rsp_chan
);

   localparam logic [10:0] ROW_W = 11'(ROW_BYTES);
   localparam logic [10:0] BUF_W = 11'(BUFFER_BYTES);

   // spread four bits into eight, each bit doubled
   function automatic logic [7:0] double_nibble(input logic [3:0] n);
      logic [7:0] r;
      r = '0;
      for (int b = 0; b < 4; b++) begin
         r[2*b +: 2] = {2{n[b]}};
      end
      return r;
   endfunction

   state_type       state_ff, state_in;
   logic [4:0]      step_ff, step_in;
   logic            dbl_ff;
   logic [9:0]      base_ff;
   logic [39:0]     glyph_ff;
   logic [9:0]      cursor_ff, cursor_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            req_fire;
   logic            out_adv;
   logic            emit;
   logic            step_last;
   logic            start;
   logic            req_ready;
   req_payload_type req;

   logic [3:0]      col_m1;
   logic [2:0]      row_m1;
   logic [10:0]     set_pos;
   logic [10:0]     cur_ext;
   logic [10:0]     adv_sum;

   logic [2:0]      col_idx;
   logic [7:0]      col_byte;
   logic [7:0]      shifted;
   logic [10:0]     addr_sum;
   logic [7:0]      beat_data;

   // handshake and sequencer status
   assign req         = req_chan.data;
   assign req_fire    = req_chan.valid && req_ready;
   assign out_adv     = !rsp_valid_ff || rsp_chan.ready;
   assign emit        = (state_ff == ST_EMIT) && out_adv;
   assign step_last   = dbl_ff ? (step_ff == STEP_LAST_DOUBLE) : (step_ff == STEP_LAST_NORMAL);
   assign cur_ext     = {1'b0, cursor_ff};
   // a doubled character in the first page row draws nothing
   assign start       = req_fire && (req.cmd == CMD_PUT_CHAR)
                        && !(req.double_size && (cur_ext < ROW_W));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit && step_last) state_in = start ? ST_EMIT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: req_ready = !reset;
         ST_EMIT: req_ready = emit && step_last;
         default: req_ready = 1'b0;
      endcase
   end

   assign req_chan.ready = req_ready;

   always_comb begin
      step_in = step_ff;
      if (start) begin
         step_in = '0;
      end else if (emit) begin
         step_in = step_ff + 5'd1;
      end
   end

   // cursor update: set position or advance past the character
   assign col_m1  = (req.text_column == 4'd0) ? 4'd0 : req.text_column - 4'd1;
   assign row_m1  = (req.text_row == 3'd0) ? 3'd0 : req.text_row - 3'd1;
   assign set_pos = 11'(col_m1) * CELL_WIDTH + 11'(row_m1) * ROW_W;
   assign adv_sum = cur_ext + (req.double_size ? ADVANCE_DOUBLE : ADVANCE_NORMAL);

   always_comb begin
      cursor_in = cursor_ff;
      if (req_fire && (req.cmd == CMD_SET_CURSOR)) begin
         cursor_in = (set_pos > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : set_pos[9:0];
      end else if (start) begin
         cursor_in = (adv_sum > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : adv_sum[9:0];
      end
   end

   // beat address and data for the current step
   assign col_idx = dbl_ff ? step_ff[4:2] : step_ff[2:0];

   always_comb begin
      case (col_idx)
         3'd0:    col_byte = glyph_ff[39:32];
         3'd1:    col_byte = glyph_ff[31:24];
         3'd2:    col_byte = glyph_ff[23:16];
         3'd3:    col_byte = glyph_ff[15:8];
         3'd4:    col_byte = glyph_ff[7:0];
         default: col_byte = 8'h00;
      endcase
   end

   assign shifted = {col_byte[6:0], 1'b0};

   always_comb begin
      if (!dbl_ff) begin
         addr_sum  = {1'b0, base_ff} + 11'(step_ff);
         beat_data = step_last ? 8'h00 : shifted;
      end else if (step_last) begin
         addr_sum  = {1'b0, base_ff} + GAP_DOUBLE;
         beat_data = 8'h00;
      end else if (step_ff[1]) begin
         // bottom half at the cursor row
         addr_sum  = {1'b0, base_ff} + 11'({step_ff[4:2], step_ff[0]});
         beat_data = double_nibble(shifted[7:4]);
      end else begin
         // top half one page row above
         addr_sum  = {1'b0, base_ff} - ROW_W + 11'({step_ff[4:2], step_ff[0]});
         beat_data = double_nibble(shifted[3:0]);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.write_address    = (addr_sum > {1'b0, CURSOR_MAX}) ? CURSOR_MAX
                                                                        : addr_sum[9:0];
         rsp_data_in.write_data       = beat_data;
         rsp_data_in.address_in_range = addr_sum < BUF_W;
         rsp_data_in.last_write       = step_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item registers and registered font ROM read
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (start) begin
         dbl_ff   <= req.double_size;
         base_ff  <= cursor_ff;
         glyph_ff <= glyph_rom(map_code(req.char_code));
      end
   end

endmodule

`default_nettype wire
